// ----- rtl/highpass_boxcar_fir_cascade_assert.svh -----
// Assertion macros shared by the highpass_boxcar_fir_cascade RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef HIGHPASS_BOXCAR_FIR_CASCADE_ASSERT_SVH
`define HIGHPASS_BOXCAR_FIR_CASCADE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HBFC_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define HBFC_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define HBFC_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`define HBFC_ASSERT_NXT(lbl, clk, rst_n, a, b, msg)
`endif

`endif

// ----- rtl/hbfc_pkg.sv -----
// Shared types, constants and coefficient function for the high-pass/boxcar cascade.
// No dependencies; used by hbfc_ctrl, hbfc_datapath and the top level.
`timescale 1ns / 1ps

package hbfc_pkg;

    localparam int HP_TAPS_DEF        = 79;
    localparam int BOX_TAPS_DEF       = 100;
    localparam int COEF_FRAC_BITS_DEF = 15;

    localparam int TABLE_TAPS = 79;
    localparam int TAP_IDX_W  = 8;
    localparam int SAMPLE_W   = 12;
    localparam int OUT_W      = 16;

    // taps 0..39 of the symmetric Q1.15 table; tap k >= 40 mirrors to 78-k
    localparam logic signed [15:0] HP_Q15_HALF [0:39] = '{
        2648, -1868, -1184, -656, -257, 43, 242, 368, 427, 427,
        378, 283, 156, 8, -144, -284, -398, -469, -485, -439,
        -329, -162, 45, 271, 489, 671, 786, 809, 720, 506,
        170, -279, -815, -1407, -2013, -2589, -3093, -3483, -3730, 28953
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_HP_ISSUE,
        S_HP_DRAIN,
        S_BOX_UPDATE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic                 tap_issue;
        logic                 tap_first;
        logic [TAP_IDX_W-1:0] tap_idx;
        logic                 hp_write;
        logic                 box_read;
        logic                 v_from_acc;
        logic                 box_update;
        logic                 out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } dp_status_t;

    function automatic int hp_coef(input logic [TAP_IDX_W-1:0] k, input int frac_bits);
        logic [5:0] idx;
        int         q;
        int         sh;
        int         u;
        if (k >= TAP_IDX_W'(TABLE_TAPS))
            return 0;
        idx = (k < TAP_IDX_W'(40)) ? k[5:0] : 6'(TAP_IDX_W'(TABLE_TAPS - 1) - k);
        q   = int'(HP_Q15_HALF[idx]);
        if (frac_bits >= 15)
            return q * (1 << (frac_bits - 15));
        sh = 15 - frac_bits;
        u  = (q + 32768) + (1 << (sh - 1));
        return (u >> sh) - (32768 >> sh);
    endfunction

endpackage

// ----- rtl/hbfc_datapath.sv -----
// Datapath: history memories, pipelined multiply-accumulate, moving sum, output register.
// Depends on hbfc_pkg; driven by hbfc_ctrl commands.
`timescale 1ns / 1ps

module hbfc_datapath #(
    parameter int HP_TAPS        = hbfc_pkg::HP_TAPS_DEF,
    parameter int BOX_TAPS       = hbfc_pkg::BOX_TAPS_DEF,
    parameter int COEF_FRAC_BITS = hbfc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [hbfc_pkg::SAMPLE_W-1:0]    in_sample,
    input  hbfc_pkg::dp_cmd_t                cmd,
    output hbfc_pkg::dp_status_t             status,
    output logic                             out_tvalid,
    input  logic                             out_tready,
    output logic signed [hbfc_pkg::OUT_W-1:0] out_sample
);

    localparam int SW        = hbfc_pkg::SAMPLE_W;
    localparam int HP_DEPTH  = HP_TAPS - 1;
    localparam int BOX_DEPTH = BOX_TAPS - 1;
    localparam int HP_AW     = (HP_DEPTH > 1) ? $clog2(HP_DEPTH) : 1;
    localparam int BOX_AW    = (BOX_DEPTH > 1) ? $clog2(BOX_DEPTH) : 1;
    localparam int COEF_W    = 16 + ((COEF_FRAC_BITS > 15) ? (COEF_FRAC_BITS - 15) : 0);
    localparam int PROD_W    = COEF_W + SW + 1;
    localparam int ACC_W     = PROD_W + $clog2(HP_TAPS);
    localparam int SUM_W     = ACC_W + $clog2(BOX_TAPS) + 1;

    // high-pass history
    logic [SW-1:0]       hp_mem [HP_DEPTH];
    logic [HP_DEPTH-1:0] hp_vld_reg;
    logic [HP_AW-1:0]    hp_wr_ptr_reg;
    logic [HP_AW-1:0]    hp_rd_ptr_reg;
    logic [SW-1:0]       hp_rdata_reg;
    logic                hp_rvld_reg;
    logic [SW-1:0]       x_reg;

    // MAC pipeline
    logic                               s1_valid_reg;
    logic                               s1_first_reg;
    logic [hbfc_pkg::TAP_IDX_W-1:0]     s1_k_reg;
    logic signed [COEF_W-1:0]           coef;
    logic [SW-1:0]                      tap_sample;
    logic signed [SW:0]                 tap_sample_s;
    logic signed [PROD_W-1:0]           prod_reg;
    logic                               prod_valid_reg;
    logic signed [ACC_W-1:0]            acc_reg;

    // moving sum
    logic [ACC_W-1:0]         box_mem [BOX_DEPTH];
    logic [BOX_DEPTH-1:0]     box_vld_reg;
    logic [BOX_AW-1:0]        box_ptr_reg;
    logic signed [ACC_W-1:0]  box_rdata_reg;
    logic                     box_rvld_reg;
    logic signed [ACC_W-1:0]  box_old;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  v_reg;

    // output
    logic                             v_neg;
    logic [SUM_W-1:0]                 v_mag;
    logic [SUM_W-1:0]                 v_quo;
    logic signed [hbfc_pkg::OUT_W-1:0] sat;
    logic signed [hbfc_pkg::OUT_W-1:0] out_sample_reg;
    logic                             out_tvalid_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.tap_issue)
        begin
            hp_rdata_reg <= hp_mem[hp_rd_ptr_reg];
        end
        if (cmd.hp_write)
        begin
            hp_mem[hp_wr_ptr_reg] <= x_reg;
        end
        if (cmd.box_read)
        begin
            box_rdata_reg <= box_mem[box_ptr_reg];
        end
        if (cmd.box_update)
        begin
            box_mem[box_ptr_reg] <= acc_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= in_sample;
        end
        if (cmd.tap_issue)
        begin
            s1_first_reg <= cmd.tap_first;
            s1_k_reg     <= cmd.tap_idx;
        end
        if (s1_valid_reg)
        begin
            prod_reg <= coef * tap_sample_s;
        end
        if (cmd.box_read)
        begin
            v_reg <= SUM_W'(acc_reg) + sum_reg;
        end
        else if (cmd.v_from_acc)
        begin
            v_reg <= SUM_W'(acc_reg);
        end
        if (cmd.out_load)
        begin
            out_sample_reg <= sat;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_vld_reg     <= '0;
            hp_wr_ptr_reg  <= '0;
            hp_rd_ptr_reg  <= '0;
            hp_rvld_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
            box_vld_reg    <= '0;
            box_ptr_reg    <= '0;
            box_rvld_reg   <= 1'b0;
            sum_reg        <= '0;
            out_tvalid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= cmd.tap_issue;
            prod_valid_reg <= s1_valid_reg;

            if (cmd.start)
            begin
                hp_rd_ptr_reg <= (hp_wr_ptr_reg == '0) ? HP_AW'(HP_DEPTH - 1)
                                                       : hp_wr_ptr_reg - 1'b1;
            end
            else if (cmd.tap_issue && !cmd.tap_first)
            begin
                hp_rd_ptr_reg <= (hp_rd_ptr_reg == '0) ? HP_AW'(HP_DEPTH - 1)
                                                       : hp_rd_ptr_reg - 1'b1;
            end
            if (cmd.tap_issue)
            begin
                hp_rvld_reg <= hp_vld_reg[hp_rd_ptr_reg];
            end
            if (cmd.hp_write)
            begin
                hp_vld_reg[hp_wr_ptr_reg] <= 1'b1;
                hp_wr_ptr_reg <= (hp_wr_ptr_reg == HP_AW'(HP_DEPTH - 1)) ? '0
                                                                         : hp_wr_ptr_reg + 1'b1;
            end

            if (cmd.start)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end

            if (cmd.box_read)
            begin
                box_rvld_reg <= box_vld_reg[box_ptr_reg];
            end
            if (cmd.box_update)
            begin
                sum_reg <= sum_reg + SUM_W'(acc_reg) - SUM_W'(box_old);
                box_vld_reg[box_ptr_reg] <= 1'b1;
                box_ptr_reg <= (box_ptr_reg == BOX_AW'(BOX_DEPTH - 1)) ? '0
                                                                       : box_ptr_reg + 1'b1;
            end

            if (cmd.out_load)
            begin
                out_tvalid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        coef         = COEF_W'(hbfc_pkg::hp_coef(s1_k_reg, COEF_FRAC_BITS));
        tap_sample   = s1_first_reg ? x_reg : (hp_rvld_reg ? hp_rdata_reg : '0);
        tap_sample_s = signed'({1'b0, tap_sample});
        box_old      = box_rvld_reg ? box_rdata_reg : '0;
    end

    // truncate toward zero, then saturate to int16
    always_comb
    begin
        v_neg = v_reg[SUM_W-1];
        v_mag = v_neg ? SUM_W'(-v_reg) : SUM_W'(v_reg);
        v_quo = v_mag >> COEF_FRAC_BITS;
        if (v_neg)
        begin
            sat = (v_quo > SUM_W'(32768)) ? -16'sd32768 : -signed'(v_quo[15:0]);
        end
        else
        begin
            sat = (v_quo > SUM_W'(32767)) ? 16'sd32767 : signed'(v_quo[15:0]);
        end
    end

    assign status.busy     = s1_valid_reg | prod_valid_reg;
    assign status.out_free = !out_tvalid_reg || out_tready;
    assign out_tvalid      = out_tvalid_reg;
    assign out_sample      = out_sample_reg;

endmodule

// ----- rtl/hbfc_ctrl.sv -----
// Controller: sequences taps, moving-sum update and output handoff; holds the mode register.
// Depends on hbfc_pkg and highpass_boxcar_fir_cascade_assert.svh.
`timescale 1ns / 1ps
`include "highpass_boxcar_fir_cascade_assert.svh"

module hbfc_ctrl #(
    parameter int HP_TAPS = hbfc_pkg::HP_TAPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_tvalid,
    output logic                 in_tready,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  hbfc_pkg::dp_status_t status,
    output hbfc_pkg::dp_cmd_t    cmd
);

    localparam int K_W = $clog2(HP_TAPS);

    hbfc_pkg::state_t state_reg;
    hbfc_pkg::state_t state_next;
    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   k_next;
    logic             mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hbfc_pkg::S_IDLE;
            k_reg     <= '0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        in_tready  = 1'b0;
        case (state_reg)
            hbfc_pkg::S_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.start  = 1'b1;
                    k_next     = '0;
                    state_next = hbfc_pkg::S_HP_ISSUE;
                end
            end
            hbfc_pkg::S_HP_ISSUE:
            begin
                cmd.tap_issue = 1'b1;
                cmd.tap_first = (k_reg == '0);
                cmd.tap_idx   = hbfc_pkg::TAP_IDX_W'(k_reg);
                if (k_reg == K_W'(HP_TAPS - 1))
                begin
                    state_next = hbfc_pkg::S_HP_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            hbfc_pkg::S_HP_DRAIN:
            begin
                if (!status.busy)
                begin
                    cmd.hp_write = 1'b1;
                    if (mode_reg)
                    begin
                        cmd.box_read = 1'b1;
                        state_next   = hbfc_pkg::S_BOX_UPDATE;
                    end
                    else
                    begin
                        cmd.v_from_acc = 1'b1;
                        state_next     = hbfc_pkg::S_OUT;
                    end
                end
            end
            hbfc_pkg::S_BOX_UPDATE:
            begin
                cmd.box_update = 1'b1;
                state_next     = hbfc_pkg::S_OUT;
            end
            hbfc_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = hbfc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hbfc_pkg::S_IDLE;
            end
        endcase
    end

    `HBFC_ASSERT_NXT(a_accept_starts_taps, clk, rst_n, in_tvalid && in_tready, state_reg == hbfc_pkg::S_HP_ISSUE && k_reg == '0, "accepted transaction did not start tap sequence")
    `HBFC_ASSERT_IMP(a_out_load_free, clk, rst_n, cmd.out_load, status.out_free, "output loaded while previous transaction pending")
    `HBFC_ASSERT_IMP(a_box_only_in_mode, clk, rst_n, cmd.box_read || cmd.box_update, mode_reg, "moving sum touched with mode off")
    `HBFC_ASSERT_IMP(a_write_after_drain, clk, rst_n, cmd.hp_write, !status.busy && !cmd.tap_issue, "history written while taps in flight")

endmodule

// ----- rtl/highpass_boxcar_fir_cascade.sv -----
// High-pass FIR with optional boxcar moving sum, one sample in, one sample out.
// Input: s_axis transaction carries one 12-bit unsigned sample in tdata[11:0].
// Output: m_axis transaction carries one signed 16-bit sample in tdata[15:0].
// Config: privacy_mode_wr_en/privacy_mode_wr_data write the 1-bit mode register;
// write only while no transaction is in flight.
// Timing: one shared multiplier walks the HP_TAPS taps, one per cycle, through a
// three-stage read/multiply/accumulate pipeline. After the taps drain the result is
// loaded into the output register; with privacy mode on, a moving-sum read-modify-write
// step comes first. The next input is taken in the cycle after the result is loaded,
// so a new item is not accepted before the last one is through.
// The output register holds the result while the receiver stalls; the next item is
// accepted and processed meanwhile and waits in the last step until it frees.
// Reset: asynchronous active low; both histories read as zero, running sum is zero,
// mode is off. No clearing pass; the block is ready right after reset.
// Depends on hbfc_pkg, hbfc_ctrl, hbfc_datapath.
`timescale 1ns / 1ps

module highpass_boxcar_fir_cascade #(
    parameter int HP_TAPS        = hbfc_pkg::HP_TAPS_DEF,
    parameter int BOX_TAPS       = hbfc_pkg::BOX_TAPS_DEF,
    parameter int COEF_FRAC_BITS = hbfc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [11:0] sample_in, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [15:0] sample_out
    input  logic        privacy_mode_wr_en,
    input  logic        privacy_mode_wr_data
);

    hbfc_pkg::dp_cmd_t    cmd;
    hbfc_pkg::dp_status_t status;
    logic signed [hbfc_pkg::OUT_W-1:0] sample_out;

    hbfc_ctrl #(
        .HP_TAPS (HP_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .cfg_we    (privacy_mode_wr_en),
        .cfg_wdata (privacy_mode_wr_data),
        .status    (status),
        .cmd       (cmd)
    );

    hbfc_datapath #(
        .HP_TAPS        (HP_TAPS),
        .BOX_TAPS       (BOX_TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_sample  (s_axis_tdata[hbfc_pkg::SAMPLE_W-1:0]),
        .cmd        (cmd),
        .status     (status),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_sample (sample_out)
    );

    assign m_axis_tdata = sample_out;

endmodule
